### hw/rtl/mcrct_pkg.sv
// Shared types and constants for the repeating countdown timer unit.
// No dependencies; imported by the timer unit top level.
`timescale 1ns / 1ps

package mcrct_pkg;

  // Operation codes carried on in_tuser.
  typedef enum logic [1:0] {
    OP_CLAIM  = 2'd0,
    OP_RELOAD = 2'd1,
    OP_BURN   = 2'd2,
    OP_NONE   = 2'd3
  } mcrct_op_t;

  // Result kinds carried on out_tuser.
  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_EXPIRY = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 40;

  // Repeat count that never runs out.
  localparam logic [15:0] REPEAT_FOREVER = 16'hFFFF;

  // One word of the timer table.
  typedef struct packed {
    logic [15:0]        tag;
    logic [15:0]        reps;
    logic signed [15:0] reload;
    logic signed [15:0] remain;
  } mcrct_entry_t;

endpackage

### hw/rtl/multi_channel_repeating_countdown_timer_unit.sv
// Top level of the repeating countdown timer unit: sequencer, timer table
// memory and output register. Depends on mcrct_pkg.
`timescale 1ns / 1ps

// A table of FUSE_COUNT countdown timers behind one stream input and one
// stream output. Each input beat carries an operation on in_tuser: claim
// takes the lowest free slot, reload loads a named slot, burn subtracts an
// amount from every timer in use. Claim and reload answer with a single
// acknowledgement beat. A burn answers with one expiry beat, in slot order,
// for every timer that reaches zero or below (its tag and its overshoot),
// followed by a closing beat with out_tlast high; the expired timer is
// reloaded with its period and its repeat count is decremented, 65535 being
// endless, and the slot is freed when the count reaches zero. Operation code
// three is dropped without any result. The block handles one operation at a
// time and lowers in_tready until that operation's last result beat has been
// placed in the output register; the output register lets the next beat in
// while that result still waits to be taken. A reload is written to the
// table and then acknowledged; a claim examines the slots one at a time,
// lowest first and at most FUSE_COUNT of them, before its acknowledgement;
// and a burn skips each free slot, reads and then updates each slot in use
// (one memory read, one update), and ends with the closing beat. The timer
// table memory is single-port: every slot goes through the one shared
// subtract and compare unit in turn. After reset every slot is free and the
// block is ready at once.
module multi_channel_repeating_countdown_timer_unit #(
  parameter int FUSE_COUNT = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata, lowest bit first: slot[3:0], tag[19:4], period[35:20],
  // repeats[51:36], amount[66:52], zero fill[71:67].
  input  logic [mcrct_pkg::IN_DATA_W-1:0]  in_tdata,
  // tuser: opcode[1:0].
  input  logic [1:0]                       in_tuser,
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata, lowest bit first: timer_id[3:0], granted[4], tag_out[20:5],
  // overshoot[36:21], zero fill[39:37].
  output logic [mcrct_pkg::OUT_DATA_W-1:0] out_tdata,
  // tuser: kind[1:0].
  output logic [1:0]                       out_tuser,
  output logic                             out_tlast
);

  import mcrct_pkg::*;

  localparam int IDX_W = (FUSE_COUNT > 1) ? $clog2(FUSE_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FUSE_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLAIM,
    S_ACK,
    S_BURN_RD,
    S_BURN_EX,
    S_DONE
  } state_t;

  state_t state_r;

  // Slot occupancy, one flip-flop per slot.
  logic [FUSE_COUNT-1:0] in_use_r;

  // Timer table and its registered read data.
  mcrct_entry_t mem [FUSE_COUNT];
  mcrct_entry_t rd_data_r;

  logic [IDX_W-1:0] idx_r;

  // Operands captured with the input beat.
  logic [15:0] tag_r;
  logic [15:0] period_r;
  logic [15:0] reps_r;
  logic [14:0] amount_r;

  // Pending acknowledgement.
  logic [3:0] ack_id_r;
  logic       ack_grant_r;

  // Output register.
  logic                  out_valid_r;
  logic [1:0]            out_kind_r;
  logic                  out_last_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Input fields.
  mcrct_op_t   in_op;
  logic [3:0]  in_slot;
  logic [15:0] in_tag;
  logic [15:0] in_period;
  logic [15:0] in_reps;
  logic [14:0] in_amount;

  assign in_op     = mcrct_op_t'(in_tuser);
  assign in_slot   = in_tdata[3:0];
  assign in_tag    = in_tdata[19:4];
  assign in_period = in_tdata[35:20];
  assign in_reps   = in_tdata[51:36];
  assign in_amount = in_tdata[66:52];

  logic in_accept;
  logic out_free;
  logic slot_ok;

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign slot_ok   = (32'(in_slot) < FUSE_COUNT);

  // Shared burn unit: saturating subtract, expiry test and repeat update.
  logic signed [16:0] diff;
  logic [15:0]        sat_val;
  logic               expired;
  logic [15:0]        reps_dec;
  logic               freed;
  mcrct_entry_t       burn_entry;

  always_comb begin
    diff    = {rd_data_r.remain[15], rd_data_r.remain} - $signed({2'b00, amount_r});
    // Below the 16-bit minimum the result clamps to it.
    sat_val = (diff[16] && !diff[15]) ? 16'h8000 : diff[15:0];
    expired = sat_val[15] || (sat_val == 16'h0000);
    reps_dec = (rd_data_r.reps == REPEAT_FOREVER) ? rd_data_r.reps
                                                  : rd_data_r.reps - 16'd1;
    freed   = (reps_dec == 16'h0000);
    burn_entry = rd_data_r;
    if (expired) begin
      burn_entry.remain = rd_data_r.reload;
      burn_entry.reps   = reps_dec;
    end else begin
      burn_entry.remain = sat_val;
    end
  end

  // Table write port.
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  mcrct_entry_t     mem_wd;
  logic             mem_re;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_r;
    mem_wd = '{tag: tag_r, reps: reps_r, reload: period_r, remain: period_r};
    unique case (state_r)
      S_IDLE: begin
        if (in_accept && in_op == OP_RELOAD && slot_ok) begin
          mem_we = 1'b1;
          mem_wa = IDX_W'(in_slot);
          mem_wd = '{tag: in_tag, reps: in_reps, reload: in_period, remain: in_period};
        end
      end
      S_CLAIM: begin
        mem_we = !in_use_r[idx_r];
      end
      S_BURN_EX: begin
        mem_we = !expired || out_free;
        mem_wd = burn_entry;
      end
      default: begin
      end
    endcase
  end

  assign mem_re = (state_r == S_BURN_RD) && in_use_r[idx_r];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[idx_r];
    end
  end

  // Sequencer, occupancy and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            tag_r    <= in_tag;
            period_r <= in_period;
            reps_r   <= in_reps;
            amount_r <= in_amount;
            idx_r    <= '0;
            unique case (in_op)
              OP_CLAIM: begin
                if (in_reps == 16'h0000) begin
                  ack_id_r    <= 4'd0;
                  ack_grant_r <= 1'b0;
                  state_r     <= S_ACK;
                end else begin
                  state_r <= S_CLAIM;
                end
              end
              OP_RELOAD: begin
                ack_grant_r <= slot_ok;
                ack_id_r    <= slot_ok ? in_slot : 4'd0;
                if (slot_ok) begin
                  in_use_r[IDX_W'(in_slot)] <= 1'b1;
                end
                state_r <= S_ACK;
              end
              OP_BURN: begin
                state_r <= S_BURN_RD;
              end
              default: begin
              end
            endcase
          end
        end
        S_CLAIM: begin
          // One slot is examined per cycle, lowest first.
          if (!in_use_r[idx_r]) begin
            in_use_r[idx_r] <= 1'b1;
            ack_id_r        <= 4'(idx_r);
            ack_grant_r     <= 1'b1;
            state_r         <= S_ACK;
          end else if (idx_r == LAST_IDX) begin
            ack_id_r    <= 4'd0;
            ack_grant_r <= 1'b0;
            state_r     <= S_ACK;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_ACK: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_ACK;
            out_last_r  <= 1'b1;
            out_data_r  <= {3'b000, 16'h0000, 16'h0000, ack_grant_r, ack_id_r};
            state_r     <= S_IDLE;
          end
        end
        S_BURN_RD: begin
          if (in_use_r[idx_r]) begin
            state_r <= S_BURN_EX;
          end else if (idx_r == LAST_IDX) begin
            state_r <= S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_BURN_EX: begin
          // An expiry waits here until the output register has room.
          if (!expired || out_free) begin
            if (expired) begin
              out_valid_r <= 1'b1;
              out_kind_r  <= KIND_EXPIRY;
              out_last_r  <= 1'b0;
              out_data_r  <= {3'b000, sat_val, rd_data_r.tag, 1'b0, 4'(idx_r)};
              if (freed) begin
                in_use_r[idx_r] <= 1'b0;
              end
            end
            if (idx_r == LAST_IDX) begin
              state_r <= S_DONE;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_BURN_RD;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_DONE;
            out_last_r  <= 1'b1;
            out_data_r  <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

### bench/tb.sv
// Self-checking bench for the repeating countdown timer unit: a directed table, then
// random claim, reload and burn traffic checked against a timer-table predictor.
// Depends on mcrct_pkg and multi_channel_repeating_countdown_timer_unit.
`timescale 1ns / 1ps

module tb;
  import mcrct_pkg::*;

  localparam int TIMERS        = 16;
  localparam int SETTLE_CYCLES = 2 * TIMERS + 8;
  localparam int PHASE_ITEMS   = 65;

  typedef struct packed {
    mcrct_op_t          op;
    logic [3:0]         slot;
    logic signed [15:0] tag;
    logic signed [15:0] period;
    logic [15:0]        repeats;
    logic [14:0]        amount;
  } timer_cmd_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         timer_id;
    logic               granted;
    logic signed [15:0] tag_out;
    logic signed [15:0] overshoot;
    logic               last;
  } timer_result_t;

  typedef struct packed {
    timer_cmd_t    cmd;
    logic          fixed;
    timer_result_t answer;
  } directed_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;

  // Predicted copy of the timer table.
  logic               busy_slot [TIMERS];
  logic signed [15:0] time_left [TIMERS];
  logic signed [15:0] period_of [TIMERS];
  logic [15:0]        runs_left [TIMERS];
  logic signed [15:0] tag_of    [TIMERS];

  timer_result_t step_results[$];
  timer_result_t awaited_results[$];
  directed_row_t directed_rows[$];

  int error_count     = 0;
  int send_gap_pct    = 20;
  int recv_gap_pct    = 47;
  int long_stall_left = 0;

  multi_channel_repeating_countdown_timer_unit #(
    .FUSE_COUNT(TIMERS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic timer_result_t make_result(logic [1:0] kind, int id, logic granted,
                                                logic [15:0] tag, logic [15:0] over,
                                                logic last);
    timer_result_t r;
    r.kind      = kind;
    r.timer_id  = 4'(id);
    r.granted   = granted;
    r.tag_out   = tag;
    r.overshoot = over;
    r.last      = last;
    return r;
  endfunction

  function automatic void load_timer(int idx, timer_cmd_t c);
    busy_slot[idx] = 1'b1;
    time_left[idx] = c.period;
    period_of[idx] = c.period;
    runs_left[idx] = c.repeats;
    tag_of[idx]    = c.tag;
  endfunction

  // Works out the result beats of one command and advances the predicted table.
  function automatic void predict_timer_op(timer_cmd_t c);
    int   idx;
    int   level;
    logic found;
    step_results.delete();
    case (c.op)
      OP_CLAIM: begin
        found = 1'b0;
        if (c.repeats != 16'd0) begin
          for (idx = 0; idx < TIMERS && !found; idx++) begin
            if (!busy_slot[idx]) begin
              load_timer(idx, c);
              step_results.push_back(make_result(KIND_ACK, idx, 1'b1, '0, '0, 1'b1));
              found = 1'b1;
            end
          end
        end
        if (!found) begin
          step_results.push_back(make_result(KIND_ACK, 0, 1'b0, '0, '0, 1'b1));
        end
      end
      OP_RELOAD: begin
        // Every 4-bit slot number names a real timer at this size.
        load_timer(int'(c.slot), c);
        step_results.push_back(make_result(KIND_ACK, int'(c.slot), 1'b1, '0, '0, 1'b1));
      end
      OP_BURN: begin
        for (idx = 0; idx < TIMERS; idx++) begin
          if (busy_slot[idx]) begin
            level = int'(time_left[idx]) - int'(c.amount);
            if (level < -32768) begin
              level = -32768;
            end
            if (level <= 0) begin
              step_results.push_back(make_result(KIND_EXPIRY, idx, 1'b0, tag_of[idx],
                                                 16'(level), 1'b0));
              time_left[idx] = period_of[idx];
              // A zero count wraps to the endless value here, as the hardware does.
              if (runs_left[idx] != REPEAT_FOREVER) begin
                runs_left[idx] = runs_left[idx] - 16'd1;
              end
              if (runs_left[idx] == 16'd0) begin
                busy_slot[idx] = 1'b0;
              end
            end else begin
              time_left[idx] = 16'(level);
            end
          end
        end
        step_results.push_back(make_result(KIND_DONE, 0, 1'b0, '0, '0, 1'b1));
      end
      default: ;
    endcase
  endfunction

  function automatic void add_row(mcrct_op_t op, int slot, int tag, int period, int reps,
                                  int amount, bit fixed = 1'b0,
                                  logic [1:0] kind = KIND_ACK, int id = 0,
                                  bit granted = 1'b0);
    directed_row_t row;
    row.cmd.op      = op;
    row.cmd.slot    = 4'(slot);
    row.cmd.tag     = 16'(tag);
    row.cmd.period  = 16'(period);
    row.cmd.repeats = 16'(reps);
    row.cmd.amount  = 15'(amount);
    row.fixed       = fixed;
    row.answer      = make_result(kind, id, granted, '0, '0, 1'b1);
    directed_rows.push_back(row);
  endfunction

  function automatic void fill_directed_table();
    int n;
    add_row(OP_BURN,   0, 0, 0, 0, 0, 1'b1, KIND_DONE, 0, 1'b0);  // burn of an empty table
    add_row(OP_CLAIM,  0, 0, 10, 0, 0, 1'b1, KIND_ACK, 0, 1'b0);  // zero repeats refused
    add_row(OP_CLAIM,  0, 32767, 5, 1, 0, 1'b1, KIND_ACK, 0, 1'b1);
    add_row(OP_CLAIM,  0, -32768, -32768, REPEAT_FOREVER, 0, 1'b1, KIND_ACK, 1, 1'b1);
    add_row(OP_CLAIM,  0, 0, 0, 2, 0, 1'b1, KIND_ACK, 2, 1'b1);
    // Reload of a free slot with zero repeats: comes into use and later wraps.
    add_row(OP_RELOAD, 15, -1, 32767, 0, 0, 1'b1, KIND_ACK, 15, 1'b1);
    add_row(OP_NONE,   15, -1, -1, 65535, 32767);                 // dropped silently
    add_row(OP_BURN,   0, 0, 0, 0, 32767);                        // saturating burn
    add_row(OP_BURN,   0, 0, 0, 0, 0);                            // non-positive periods
    add_row(OP_RELOAD, 3, 1234, 3, 3, 0, 1'b1, KIND_ACK, 3, 1'b1);
    add_row(OP_BURN,   0, 0, 0, 0, 1);
    // Slots 1, 3 and 15 are now in use; claims fill every remaining slot.
    for (n = 0; n < 13; n++) begin
      add_row(OP_CLAIM, 0, n * 2311 - 15000, 100, 1, 0, 1'b1, KIND_ACK,
              (n == 0) ? 0 : (n == 1) ? 2 : n + 2, 1'b1);
    end
    add_row(OP_CLAIM,  0, 77, 100, 1, 0, 1'b1, KIND_ACK, 0, 1'b0);  // table full
    add_row(OP_BURN,   0, 0, 0, 0, 32767);                           // every timer expires
  endfunction

  function automatic timer_cmd_t random_cmd();
    timer_cmd_t c;
    int         pick;
    c.slot    = 4'($urandom);
    c.tag     = 16'($urandom);
    c.period  = 16'(int'($urandom_range(0, 205)) - 5);
    c.amount  = 15'($urandom_range(0, 150));
    c.repeats = 16'($urandom_range(1, 4));
    if ($urandom_range(0, 9) == 0) begin
      c.period = 16'($urandom);
    end
    if ($urandom_range(0, 9) == 0) begin
      c.amount = 15'($urandom);
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      c.repeats = REPEAT_FOREVER;
    end else if (pick == 1) begin
      c.repeats = 16'($urandom);
    end else if (pick == 2) begin
      c.repeats = 16'd0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 32) begin
      c.op = OP_CLAIM;
    end else if (pick < 52) begin
      c.op = OP_RELOAD;
    end else if (pick < 95) begin
      c.op = OP_BURN;
    end else begin
      c.op = OP_NONE;
    end
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_cmd(timer_cmd_t c, logic fixed, timer_result_t answer);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c.op;
    in_tdata  <= {5'd0, c.amount, c.repeats, c.period, c.tag, c.slot};
    do @(posedge clk); while (!in_tready);
    predict_timer_op(c);
    if (fixed) begin
      awaited_results.push_back(answer);
    end else begin
      foreach (step_results[k]) begin
        awaited_results.push_back(step_results[k]);
      end
    end
    @(negedge clk);
  endtask

  // Result side: random back-pressure, or a counted long stall when one is asked for.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_left > 0) begin
        out_tready <= 1'b0;
        long_stall_left--;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    timer_result_t seen;
    timer_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.kind      = out_tuser;
      seen.timer_id  = out_tdata[3:0];
      seen.granted   = out_tdata[4];
      seen.tag_out   = out_tdata[20:5];
      seen.overshoot = out_tdata[36:21];
      seen.last      = out_tlast;
      if (awaited_results.size() == 0) begin
        $error("unexpected result beat: kind %0d timer_id %0d", seen.kind, seen.timer_id);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("kind", int'(want.kind), int'(seen.kind));
        check_field("timer_id", int'(want.timer_id), int'(seen.timer_id));
        check_field("granted", int'(want.granted), int'(seen.granted));
        check_field("tag_out", int'(want.tag_out), int'(seen.tag_out));
        check_field("overshoot", int'(want.overshoot), int'(seen.overshoot));
        check_field("last", int'(want.last), int'(seen.last));
      end
    end
  end

  initial begin
    timer_cmd_t c;
    int         sent;
    int         phase;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_NONE;
    for (int k = 0; k < TIMERS; k++) begin
      busy_slot[k] = 1'b0;
    end
    fill_directed_table();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      send_cmd(directed_rows[r].cmd, directed_rows[r].fixed, directed_rows[r].answer);
    end

    // Receiver idles more than sender, then the reverse, then neither idles,
    // opening the last phase with a long receiver stall to back the block up.
    for (phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_gap_pct = 47;
        recv_gap_pct = 20;
      end else if (phase == 2) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
        @(posedge clk);
        long_stall_left = 300;
        @(negedge clk);
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        c = random_cmd();
        send_cmd(c, 1'b0, '0);
        if (c.op != OP_NONE) begin
          sent++;
        end
      end
    end

    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
